>>> rtl/core/vau_pkg.sv
`timescale 1ns / 1ps
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_STAGES = 32;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_SCALE  = 4'd2,
    OP_DIV    = 4'd3,
    OP_EQUAL  = 4'd4,
    OP_DOT    = 4'd5,
    OP_CROSS  = 4'd6,
    OP_LENGTH = 4'd7,
    OP_NORM   = 4'd8
  } op_t;

  // everything an item carries down the pipe besides the wide datapath words
  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][31:0] r;
    logic [31:0]      rs;
    logic             eq;
    logic             dz;
    logic             ov;
  } ctx_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] v;
  } sat_t;

  // clamp a wide signed value into 32 bits
  function automatic sat_t sat66(input logic signed [65:0] v);
    sat_t res;
    res.ov = !((&v[65:31]) || !(|v[65:31]));
    if (res.ov) begin
      res.v = v[65] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      res.v = v[31:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/vau_front.sv
`timescale 1ns / 1ps
module vau_front #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [3:0]          op,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  az,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [31:0]  bz,
  input  logic signed [31:0]  scalar,
  output logic                out_valid,
  output vau_pkg::ctx_t       out_ctx,
  output logic [63:0]         sq
);

  // stage 1: operand capture
  logic               v1;
  logic [3:0]         op1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [31:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    op1   <= op;
    a1[0] <= ax;
    a1[1] <= ay;
    a1[2] <= az;
    b1[0] <= bx;
    b1[1] <= by;
    b1[2] <= bz;
    s1    <= scalar;
  end

  // stage 2: two multipliers per lane, add/sub
  logic signed [31:0] m0a [3];
  logic signed [31:0] m0b [3];
  logic signed [31:0] m1a [3];
  logic signed [31:0] m1b [3];
  logic signed [32:0] as_sum [3];
  vau_pkg::sat_t      as_sat [3];

  always_comb begin
    int j;
    int k;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      m0a[i] = a1[i];
      m0b[i] = '0;
      m1a[i] = '0;
      m1b[i] = '0;
      case (op1)
        vau_pkg::OP_SCALE: m0b[i] = s1;
        vau_pkg::OP_DOT: m0b[i] = b1[i];
        vau_pkg::OP_LENGTH, vau_pkg::OP_NORM: m0b[i] = a1[i];
        vau_pkg::OP_CROSS: begin
          m0a[i] = a1[j];
          m0b[i] = b1[k];
          m1a[i] = a1[k];
          m1b[i] = b1[j];
        end
        default: ;
      endcase
      if (op1 == vau_pkg::OP_SUB) begin
        as_sum[i] = 33'(a1[i]) - 33'(b1[i]);
      end else begin
        as_sum[i] = 33'(a1[i]) + 33'(b1[i]);
      end
      as_sat[i] = vau_pkg::sat66(66'(as_sum[i]));
    end
  end

  logic               v2;
  logic [3:0]         op2;
  logic signed [31:0] a2 [3];
  logic signed [31:0] s2;
  logic signed [63:0] p0 [3];
  logic signed [63:0] p1 [3];
  logic [31:0]        r2 [3];
  logic               ov2;
  logic               eq2;
  logic               is_as;

  assign is_as = (op1 == vau_pkg::OP_ADD) || (op1 == vau_pkg::OP_SUB);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2 <= op1;
    s2  <= s1;
    for (int i = 0; i < 3; i++) begin
      a2[i] <= a1[i];
      p0[i] <= m0a[i] * m0b[i];
      p1[i] <= m1a[i] * m1b[i];
      r2[i] <= is_as ? as_sat[i].v : 32'd0;
    end
    ov2 <= is_as && (as_sat[0].ov || as_sat[1].ov || as_sat[2].ov);
    eq2 <= (op1 == vau_pkg::OP_EQUAL) && (a1[0] == b1[0]) && (a1[1] == b1[1])
           && (a1[2] == b1[2]);
  end

  // stage 3: lane differences and the three-term sum
  logic               v3;
  logic [3:0]         op3;
  logic signed [31:0] a3 [3];
  logic signed [31:0] s3;
  logic [31:0]        r3 [3];
  logic               ov3;
  logic               eq3;
  logic signed [65:0] lane3 [3];
  logic signed [65:0] d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    op3 <= op2;
    s3  <= s2;
    ov3 <= ov2;
    eq3 <= eq2;
    for (int i = 0; i < 3; i++) begin
      a3[i] <= a2[i];
      r3[i] <= r2[i];
      if (op2 == vau_pkg::OP_CROSS) begin
        lane3[i] <= 66'(p0[i]) - 66'(p1[i]);
      end else begin
        lane3[i] <= 66'(p0[i]);
      end
    end
    d3 <= 66'(p0[0]) + 66'(p0[1]) + 66'(p0[2]);
  end

  // stage 4: floor shift and clamp
  vau_pkg::sat_t lane_sat [3];
  vau_pkg::sat_t dot_sat;
  vau_pkg::ctx_t ctx4;
  logic          use_lane;
  logic          is_dot;

  always_comb begin
    use_lane = (op3 == vau_pkg::OP_SCALE) || (op3 == vau_pkg::OP_CROSS);
    is_dot   = (op3 == vau_pkg::OP_DOT);
    dot_sat  = vau_pkg::sat66(d3 >>> FRAC_BITS);
    ctx4.op  = op3;
    ctx4.s   = s3;
    ctx4.eq  = eq3;
    ctx4.dz  = 1'b0;
    ctx4.ov  = ov3 || (is_dot && dot_sat.ov);
    ctx4.rs  = is_dot ? dot_sat.v : 32'd0;
    for (int i = 0; i < 3; i++) begin
      lane_sat[i] = vau_pkg::sat66(lane3[i] >>> FRAC_BITS);
      ctx4.a[i]   = a3[i];
      ctx4.r[i]   = use_lane ? lane_sat[i].v : r3[i];
      if (use_lane && lane_sat[i].ov) begin
        ctx4.ov = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    out_ctx <= ctx4;
    sq      <= d3[63:0];
  end

endmodule

>>> rtl/core/vau_sqrt.sv
`timescale 1ns / 1ps
module vau_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  vau_pkg::ctx_t in_ctx,
  input  logic [63:0]   in_sq,
  output logic          out_valid,
  output vau_pkg::ctx_t out_ctx,
  output logic [31:0]   out_len
);

  localparam int N = vau_pkg::SQ_STAGES;

  // one root bit per stage, two radicand bits consumed per stage
  logic          vld  [N];
  vau_pkg::ctx_t cx   [N];
  logic [63:0]   rad  [N];
  logic [33:0]   rem  [N];
  logic [31:0]   root [N];
  logic [63:0]   rad_next  [N];
  logic [33:0]   rem_next  [N];
  logic [31:0]   root_next [N];

  always_comb begin
    logic [63:0] rad_i;
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [35:0] rem4;
    logic [35:0] trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rad_i  = in_sq;
        rem_i  = '0;
        root_i = '0;
      end else begin
        rad_i  = rad[k-1];
        rem_i  = rem[k-1];
        root_i = root[k-1];
      end
      rem4  = {rem_i, rad_i[63:62]};
      trial = {2'b00, root_i, 2'b01};
      if (rem4 >= trial) begin
        rem_next[k]  = 34'(rem4 - trial);
        root_next[k] = {root_i[30:0], 1'b1};
      end else begin
        rem_next[k]  = rem4[33:0];
        root_next[k] = {root_i[30:0], 1'b0};
      end
      rad_next[k] = {rad_i[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= (k == 0) ? in_valid : vld[k-1];
      end
      cx[k]   <= (k == 0) ? in_ctx : cx[k-1];
      rad[k]  <= rad_next[k];
      rem[k]  <= rem_next[k];
      root[k] <= root_next[k];
    end
  end

  assign out_valid = vld[N-1];
  assign out_ctx   = cx[N-1];
  assign out_len   = root[N-1];

endmodule

>>> rtl/core/vau_div.sv
`timescale 1ns / 1ps
module vau_div #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  vau_pkg::ctx_t in_ctx,
  input  logic [31:0]   in_len,
  output logic          out_valid,
  output vau_pkg::ctx_t out_ctx
);

  localparam int NQ = 32 + FRAC_BITS;

  // entry: divisor pick, magnitudes, length result
  vau_pkg::ctx_t ectx_next;
  logic [31:0]   ed_next;
  logic [31:0]   emag_next [3];
  logic [2:0]    eneg_next;
  logic          is_div;
  logic          is_norm;

  always_comb begin
    is_div    = (in_ctx.op == vau_pkg::OP_DIV);
    is_norm   = (in_ctx.op == vau_pkg::OP_NORM);
    ectx_next = in_ctx;
    ectx_next.dz = (is_div && (in_ctx.s == 32'd0)) || (is_norm && (in_len == 32'd0));
    if (in_ctx.op == vau_pkg::OP_LENGTH) begin
      ectx_next.rs = in_len[31] ? 32'h7fff_ffff : in_len;
      ectx_next.ov = in_len[31];
    end
    if (is_div) begin
      ed_next = in_ctx.s[31] ? (~in_ctx.s + 32'd1) : in_ctx.s;
    end else begin
      ed_next = in_len;
    end
    for (int i = 0; i < 3; i++) begin
      emag_next[i] = in_ctx.a[i][31] ? (~in_ctx.a[i] + 32'd1) : in_ctx.a[i];
      eneg_next[i] = in_ctx.a[i][31] ^ (is_div && in_ctx.s[31]);
    end
  end

  logic          ev;
  vau_pkg::ctx_t ectx;
  logic [31:0]   ed;
  logic [31:0]   emag [3];
  logic [2:0]    eneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else begin
      ev <= in_valid;
    end
    ectx <= ectx_next;
    ed   <= ed_next;
    eneg <= eneg_next;
    for (int i = 0; i < 3; i++) begin
      emag[i] <= emag_next[i];
    end
  end

  // restoring division, one quotient bit per stage for all three lanes
  logic          qv   [NQ];
  vau_pkg::ctx_t qc   [NQ];
  logic [31:0]   qd   [NQ];
  logic [2:0]    qneg [NQ];
  logic [32:0]   qrem [NQ][3];
  logic [NQ-1:0] qdd  [NQ][3];
  logic [32:0]   qrem_next [NQ][3];
  logic [NQ-1:0] qdd_next  [NQ][3];

  always_comb begin
    logic [32:0]   rem_i;
    logic [NQ-1:0] dd_i;
    logic [31:0]   d_i;
    logic [33:0]   rem2;
    logic          ge;
    for (int k = 0; k < NQ; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          rem_i = '0;
          dd_i  = {emag[i], {FRAC_BITS{1'b0}}};
          d_i   = ed;
        end else begin
          rem_i = qrem[k-1][i];
          dd_i  = qdd[k-1][i];
          d_i   = qd[k-1];
        end
        rem2 = {rem_i, dd_i[NQ-1]};
        ge   = (rem2 >= {2'b00, d_i});
        qrem_next[k][i] = ge ? 33'(rem2 - {2'b00, d_i}) : rem2[32:0];
        qdd_next[k][i]  = {dd_i[NQ-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NQ; k++) begin
      if (rst) begin
        qv[k] <= 1'b0;
      end else begin
        qv[k] <= (k == 0) ? ev : qv[k-1];
      end
      qc[k]   <= (k == 0) ? ectx : qc[k-1];
      qd[k]   <= (k == 0) ? ed : qd[k-1];
      qneg[k] <= (k == 0) ? eneg : qneg[k-1];
      for (int i = 0; i < 3; i++) begin
        qrem[k][i] <= qrem_next[k][i];
        qdd[k][i]  <= qdd_next[k][i];
      end
    end
  end

  // sign restore and clamp
  vau_pkg::ctx_t    fctx;
  logic signed [NQ:0] ext [3];
  logic signed [NQ:0] sval [3];
  vau_pkg::sat_t    qsat [3];
  logic             use_q;

  always_comb begin
    fctx  = qc[NQ-1];
    use_q = ((fctx.op == vau_pkg::OP_DIV) || (fctx.op == vau_pkg::OP_NORM)) && !fctx.dz;
    for (int i = 0; i < 3; i++) begin
      ext[i]  = $signed({1'b0, qdd[NQ-1][i]});
      sval[i] = qneg[NQ-1][i] ? -ext[i] : ext[i];
      qsat[i] = vau_pkg::sat66(66'(sval[i]));
      if (use_q) begin
        fctx.r[i] = qsat[i].v;
        if (qsat[i].ov) begin
          fctx.ov = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= qv[NQ-1];
    end
    out_ctx <= fctx;
  end

endmodule

>>> rtl/core/vec3_arith_unit_core.sv
`timescale 1ns / 1ps
// Three-component vector ALU in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). A beat is taken on every rising edge with start high;
// busy is never raised, so a new beat may follow in every cycle. Each beat
// returns one result beat, in order, with done high for exactly one cycle.
// Every opcode takes the same path, at Q16.16 as at other FRAC_BITS values:
// a 4-stage multiply and sum front end, a 32-stage square root pipe (one
// root bit per stage) and a restoring divider with one quotient bit per
// stage over 32 + FRAC_BITS stages, plus entry and output registers. The
// receiver cannot stall, so results must be taken as they appear. Scale,
// dot and cross round toward minus infinity, divide and normalize truncate
// toward zero, length is the floor of the root; every result that does not
// fit clamps to 32 bits and raises overflow.
module vec3_arith_unit_core #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scalar,
  output logic               done,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] rscalar,
  output logic               equal_flag,
  output logic               div_zero,
  output logic               overflow
);

  // edge count from the accepting edge to the edge that takes the result
  localparam int LAT = 7 + vau_pkg::SQ_STAGES + 32 + FRAC_BITS;

  // fully pipelined, nothing ever holds the front off
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // front end: add/sub, equality, multiplies, sums, floor shift, clamp
  logic          f_valid;
  vau_pkg::ctx_t f_ctx;
  logic [63:0]   f_sq;

  vau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .op       (op),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by       (by),
    .bz       (bz),
    .scalar   (scalar),
    .out_valid(f_valid),
    .out_ctx  (f_ctx),
    .sq       (f_sq)
  );

  // sum of squares to length; every beat walks through it
  logic          s_valid;
  vau_pkg::ctx_t s_ctx;
  logic [31:0]   s_len;

  vau_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ctx   (f_ctx),
    .in_sq    (f_sq),
    .out_valid(s_valid),
    .out_ctx  (s_ctx),
    .out_len  (s_len)
  );

  // divide by scalar or by length, zero divisor flagged at entry
  logic          d_valid;
  vau_pkg::ctx_t d_ctx;

  vau_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_ctx   (s_ctx),
    .in_len   (s_len),
    .out_valid(d_valid),
    .out_ctx  (d_ctx)
  );

  // output register: one cycle strobe per result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    rx         <= d_ctx.r[0];
    ry         <= d_ctx.r[1];
    rz         <= d_ctx.r[2];
    rscalar    <= d_ctx.rs;
    equal_flag <= d_ctx.eq;
    div_zero   <= d_ctx.dz;
    overflow   <= d_ctx.ov;
  end

`ifndef SYNTHESIS
  // each result beat answers an earlier accepted beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result beat without matching input beat");

  // a zero divisor gives a zero vector and no clamp
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && div_zero) |-> (rx == 32'sd0 && ry == 32'sd0 && rz == 32'sd0 && !overflow))
    else $error("div_zero with nonzero vector or overflow");

  // an equality hit leaves rscalar, rx, overflow and div_zero clear
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    (done && equal_flag) |-> (rscalar == 32'sd0 && rx == 32'sd0 && !overflow && !div_zero))
    else $error("equal_flag with stray result fields");
`endif

endmodule

>>> test/vec3_arith_unit_core_test.sv
`timescale 1ns / 1ps
module vec3_arith_unit_core_test;

  localparam int FB = 16;
  localparam int LATENCY = 86;
  localparam int N_RANDOM = 1530;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a[3];
    logic [31:0] b[3];
    logic [31:0] s;
  } vec_item_t;

  typedef struct {
    logic [31:0] r[3];
    logic [31:0] rs;
    logic        eq;
    logic        dz;
    logic        ov;
  } vec_res_t;

  // directed row: item plus optional typed-in result
  typedef struct {
    vec_item_t item;
    bit        typed;
    vec_res_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] op = '0;
  logic signed [31:0] ax = '0, ay = '0, az = '0;
  logic signed [31:0] bx = '0, by = '0, bz = '0;
  logic signed [31:0] scalar = '0;
  logic busy, done, equal_flag, div_zero, overflow;
  logic signed [31:0] rx, ry, rz, rscalar;

  vec_res_t pending_results[$];
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int cycles = 0;
  int op_seen[16];

  always #4 clk = ~clk;

  vec3_arith_unit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .scalar(scalar),
    .done(done), .rx(rx), .ry(ry), .rz(rz), .rscalar(rscalar),
    .equal_flag(equal_flag), .div_zero(div_zero), .overflow(overflow)
  );

  // clamp a wide exact value to 32 bits, flag any clamp
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
    if (v > $signed(128'sh7fff_ffff)) begin
      ov = 1'b1;
      return MAXV;
    end
    if (v < -$signed(128'sh8000_0000)) begin
      ov = 1'b1;
      return MINV;
    end
    return v[31:0];
  endfunction

  // floor of exact sqrt, bitwise
  function automatic logic [63:0] floor_root(input logic [65:0] n);
    logic [65:0] r, b, rem;
    r = 0;
    rem = n;
    b = 66'd1 << 64;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // expected outputs of one vector operation
  function automatic vec_res_t vec_predict(input vec_item_t it);
    vec_res_t e;
    logic signed [127:0] a[3], b[3], s, acc, len;
    logic [65:0] sq;
    e.r = '{0, 0, 0};
    e.rs = 0;
    e.eq = 0;
    e.dz = 0;
    e.ov = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = 128'($signed(it.a[i]));
      b[i] = 128'($signed(it.b[i]));
    end
    s = 128'($signed(it.s));
    case (it.op)
      vau_pkg::OP_ADD: for (int i = 0; i < 3; i++) e.r[i] = clamp32(a[i] + b[i], e.ov);
      vau_pkg::OP_SUB: for (int i = 0; i < 3; i++) e.r[i] = clamp32(a[i] - b[i], e.ov);
      // arithmetic shift of a signed value is floor
      vau_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) e.r[i] = clamp32((a[i] * s) >>> FB, e.ov);
      end
      vau_pkg::OP_DIV: begin
        if (s == 0) e.dz = 1'b1;
        else for (int i = 0; i < 3; i++) e.r[i] = clamp32((a[i] <<< FB) / s, e.ov);
      end
      vau_pkg::OP_EQUAL: begin
        e.eq = (it.a[0] == it.b[0]) && (it.a[1] == it.b[1]) && (it.a[2] == it.b[2]);
      end
      vau_pkg::OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        e.rs = clamp32(acc >>> FB, e.ov);
      end
      vau_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          acc = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
          e.r[i] = clamp32(acc >>> FB, e.ov);
        end
      end
      vau_pkg::OP_LENGTH, vau_pkg::OP_NORM: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 66'(a[i] * a[i]);
        // the squared sum wraps at 64 bits
        len = {64'd0, floor_root({2'b00, sq[63:0]})};
        if (it.op == vau_pkg::OP_LENGTH) e.rs = clamp32(len, e.ov);
        else if (len == 0) e.dz = 1'b1;
        else for (int i = 0; i < 3; i++) e.r[i] = clamp32((a[i] <<< FB) / len, e.ov);
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
      3: return 32'($signed($urandom_range(0, 200)) - 100);
      4, 5: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t it;
    it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    for (int i = 0; i < 3; i++) begin
      it.a[i] = rand_word();
      it.b[i] = rand_word();
    end
    it.s = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_word();
    // equality hits need matching vectors
    if (it.op == vau_pkg::OP_EQUAL && $urandom_range(0, 1)) begin
      it.b = it.a;
      if ($urandom_range(0, 1)) it.b[$urandom_range(0, 2)] ^= 32'd1 << $urandom_range(0, 31);
    end
    if (it.op == vau_pkg::OP_NORM && $urandom_range(0, 9) == 0) it.a = '{0, 0, 0};
    return it;
  endfunction

  function automatic vec_item_t mk(input logic [3:0] o, input logic [31:0] x0, x1, x2,
                                   input logic [31:0] y0, y1, y2, input logic [31:0] sv);
    vec_item_t it;
    it.op = o;
    it.a = '{x0, x1, x2};
    it.b = '{y0, y1, y2};
    it.s = sv;
    return it;
  endfunction

  function automatic vec_res_t rz_res(input logic [31:0] r0, r1, r2, rsv,
                                      input logic e, d, o);
    vec_res_t r;
    r.r = '{r0, r1, r2};
    r.rs = rsv;
    r.eq = e;
    r.dz = d;
    r.ov = o;
    return r;
  endfunction

  // one beat: wait for an idle gap decision, present, wait for accept
  task automatic send_beat(input vec_item_t it, input vec_res_t exp_res, input bit quiet);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    op <= it.op;
    ax <= it.a[0]; ay <= it.a[1]; az <= it.a[2];
    bx <= it.b[0]; by <= it.b[1]; bz <= it.b[2];
    scalar <= it.s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(exp_res);
    op_seen[it.op]++;
    n_items++;
  endtask

  // result checker: sampled on every edge with done high
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        vec_res_t e;
        e = pending_results.pop_front();
        n_checked++;
        if (rx !== e.r[0]) begin $error("rx exp %h got %h", e.r[0], rx); errors++; end
        if (ry !== e.r[1]) begin $error("ry exp %h got %h", e.r[1], ry); errors++; end
        if (rz !== e.r[2]) begin $error("rz exp %h got %h", e.r[2], rz); errors++; end
        if (rscalar !== e.rs) begin
          $error("rscalar exp %h got %h", e.rs, rscalar);
          errors++;
        end
        if (equal_flag !== e.eq) begin
          $error("equal_flag exp %b got %b", e.eq, equal_flag);
          errors++;
        end
        if (div_zero !== e.dz) begin
          $error("div_zero exp %b got %b", e.dz, div_zero);
          errors++;
        end
        if (overflow !== e.ov) begin
          $error("overflow exp %b got %b", e.ov, overflow);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    vec_item_t it;
    int tail;

    // typed-in rows: extremes, error codes, unused codes
    rows.push_back('{mk(vau_pkg::OP_ADD, MAXV, MINV, ONE, ONE, MINV, ONE, 0), 1,
                     rz_res(MAXV, MINV, 32'h0002_0000, 0, 0, 0, 1)});
    rows.push_back('{mk(vau_pkg::OP_SUB, MINV, MAXV, 0, ONE, MINV, 0, 0), 1,
                     rz_res(MINV, MAXV, 0, 0, 0, 0, 1)});
    rows.push_back('{mk(vau_pkg::OP_DIV, ONE, MAXV, MINV, 0, 0, 0, 0), 1,
                     rz_res(0, 0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk(vau_pkg::OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE), 1,
                     rz_res(0, 0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk(vau_pkg::OP_EQUAL, MAXV, MINV, 5, MAXV, MINV, 5, 0), 1,
                     rz_res(0, 0, 0, 0, 1, 0, 0)});
    rows.push_back('{mk(vau_pkg::OP_EQUAL, MAXV, MINV, 5, MAXV, MINV, 4, 0), 1,
                     rz_res(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(4'd9, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1,
                     rz_res(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(4'd15, MINV, MINV, MINV, MINV, MINV, MINV, 0), 1,
                     rz_res(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(vau_pkg::OP_LENGTH, 0, 0, 0, 0, 0, 0, 0), 1,
                     rz_res(0, 0, 0, 0, 0, 0, 0)});
    // predictor-checked rows
    rows.push_back('{mk(vau_pkg::OP_SCALE, MAXV, MINV, 32'hffff_ffff, 0, 0, 0, MINV), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_SCALE, 3, 32'hffff_fffd, ONE, 0, 0, 0, 32'h0000_8000), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_DIV, MINV, MAXV, 7, 0, 0, 0, 32'hffff_ffff), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_DIV, 32'hffff_fff9, 7, ONE, 0, 0, 0, 32'h0003_0000), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_DOT, 1, 32'hffff_ffff, 3, 1, 1, 32'hffff_ffff, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_CROSS, MAXV, MINV, ONE, MINV, MAXV, 32'hffff_0000, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_LENGTH, MINV, MINV, MINV, 0, 0, 0, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_LENGTH, MAXV, MAXV, MAXV, 0, 0, 0, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_NORM, MINV, MINV, MINV, 0, 0, 0, 0), 0,
                     '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(vau_pkg::OP_NORM, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0, 0, 0), 0,
                     '{default: 0}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.item, row.typed ? row.res : vec_predict(row.item), 1'b0);
    end

    // random part; a burst in the middle runs back to back
    for (int n = 0; n < N_RANDOM; n++) begin
      it = rand_item();
      send_beat(it, vec_predict(it), n >= 600 && n < 900);
    end
    start <= 1'b0;

    tail = 0;
    while (pending_results.size() != 0 && tail < 4 * LATENCY) begin
      @(posedge clk);
      tail++;
    end
    repeat (LATENCY + 10) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("sent %0d beats, checked %0d results", n_items, n_checked);
    $display("per opcode: add %0d sub %0d scale %0d div %0d eq %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("  dot %0d cross %0d len %0d norm %0d",
             op_seen[5], op_seen[6], op_seen[7], op_seen[8]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
